// ----- hdl/esc_pkg.sv -----
// -----------------------------------------------------------------------------
// esc_pkg: shared types and constants for the sensor compensation pipeline
// Holds the transfer payload structs, the unpacked calibration record, the
// register index codes and the fixed constants of the integer formulas.
// -----------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

   // Register index codes of the configuration port
   localparam int CsrIdxW = 3;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_TEMP_CAL = 3'd0,
      CSR_PRES_A   = 3'd1,
      CSR_PRES_B   = 3'd2,
      CSR_PRES_C   = 3'd3,
      CSR_HUM_A    = 3'd4,
      CSR_HUM_B    = 3'd5
   } csr_index_type;

   // Formula constants
   localparam logic signed [33:0] TempPresOffset = 34'sd128000;
   localparam logic [20:0]        PresFull       = 21'd1048576;
   localparam logic [11:0]        PresScale      = 12'd3125;
   localparam logic signed [31:0] TempHumOffset  = 32'sd76800;
   localparam logic [31:0]        HumRoundX      = 32'd16384;
   localparam logic signed [31:0] HumOffsetY     = 32'sd2097152;
   localparam logic signed [31:0] HumOffsetY2    = 32'sd32768;
   localparam logic [31:0]        HumRoundY      = 32'd8192;
   localparam logic [31:0]        HumLimit       = 32'd419430400;
   localparam logic [16:0]        HumMax         = 17'd102400;
   localparam logic [63:0]        PresBias47     = 64'h0000_8000_0000_0000;
   localparam int                 DivSteps       = 64;

   typedef struct packed {
      logic [19:0] raw_temperature;
      logic [19:0] raw_pressure;
      logic [15:0] raw_humidity;
   } req_type;

   typedef struct packed {
      logic signed [31:0] temperature_centi;
      logic signed [31:0] fine_temperature;
      logic [31:0]        pressure_q24_8;
      logic               pressure_invalid;
      logic [16:0]        humidity_q22_10;
   } rsp_type;

   // Calibration words split out of the packed registers
   typedef struct packed {
      logic [15:0]        t1;
      logic signed [15:0] t2;
      logic signed [15:0] t3;
      logic [15:0]        p1;
      logic signed [15:0] p2;
      logic signed [15:0] p3;
      logic signed [15:0] p4;
      logic signed [15:0] p5;
      logic signed [15:0] p6;
      logic signed [15:0] p7;
      logic signed [15:0] p8;
      logic signed [15:0] p9;
      logic [7:0]         h1;
      logic signed [15:0] h2;
      logic [7:0]         h3;
      logic signed [11:0] h4;
      logic signed [11:0] h5;
      logic signed [7:0]  h6;
   } cal_type;

endpackage

`default_nettype wire

// ----- hdl/esc_temp.sv -----
// -----------------------------------------------------------------------------
// esc_temp: temperature compensation pipeline
// Four stages: first products, cubic term product, fine temperature, and
// the centi-degree scaling. Side data travels along with the valid bits.
// -----------------------------------------------------------------------------
`default_nettype none

module esc_temp #(
   parameter int SideW = 36
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_valid,
   input  wire logic [19:0]         raw_temperature,
   input  wire esc_pkg::cal_type    cal,
   input  wire logic [SideW-1:0]    in_side,
   output logic                     out_valid,
   output logic signed [31:0]       fine_temp,
   output logic signed [31:0]       temp_centi,
   output logic [SideW-1:0]         out_side
);

   logic               vld_ff [0:3];
   logic [SideW-1:0]   side_ff [0:3];

   logic signed [17:0] a_w;
   logic signed [16:0] d_w;
   logic signed [33:0] pa_in, pa_ff, pd_in, pd_ff;
   logic signed [31:0] tv1_in, tv1_ff, dd_w;
   logic signed [47:0] p3_in, p3_ff;
   logic signed [31:0] tv2_w, tf_in, tf_ff;
   logic signed [31:0] t5_w, tr_w, tc_in, tc_ff, tf4_ff;

   always_comb begin
      a_w    = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
      d_w    = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, cal.t1});
      pa_in  = a_w * $signed(cal.t2);
      pd_in  = d_w * d_w;
      tv1_in = $signed(pa_ff[31:0]) >>> 11;
      dd_w   = $signed(pd_ff[31:0]) >>> 12;
      p3_in  = dd_w * $signed(cal.t3);
      tv2_w  = $signed(p3_ff[31:0]) >>> 14;
      tf_in  = tv1_ff + tv2_w;
      t5_w   = tf_ff + (tf_ff <<< 2);
      tr_w   = t5_w + 32'sd128;
      tc_in  = tr_w >>> 8;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
         vld_ff[1] <= 1'b0;
         vld_ff[2] <= 1'b0;
         vld_ff[3] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
         vld_ff[1] <= vld_ff[0];
         vld_ff[2] <= vld_ff[1];
         vld_ff[3] <= vld_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff      <= pa_in;
         pd_ff      <= pd_in;
         side_ff[0] <= in_side;
         tv1_ff     <= tv1_in;
         p3_ff      <= p3_in;
         side_ff[1] <= side_ff[0];
         tf_ff      <= tf_in;
         side_ff[2] <= side_ff[1];
         tc_ff      <= tc_in;
         tf4_ff     <= tf_ff;
         side_ff[3] <= side_ff[2];
      end
   end

   assign out_valid  = vld_ff[3];
   assign fine_temp  = tf4_ff;
   assign temp_centi = tc_ff;
   assign out_side   = side_ff[3];

endmodule

`default_nettype wire

// ----- hdl/esc_hum.sv -----
// -----------------------------------------------------------------------------
// esc_hum: humidity compensation pipeline
// Seven stages of 32-bit wrapping products on the main path, ending in
// the clamp to 0..100 %RH and the Q22.10 result.
// -----------------------------------------------------------------------------
`default_nettype none

module esc_hum #(
   parameter int SideW = 84
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_valid,
   input  wire logic signed [31:0]  fine_temp,
   input  wire logic [15:0]         raw_humidity,
   input  wire esc_pkg::cal_type    cal,
   input  wire logic [SideW-1:0]    in_side,
   output logic                     out_valid,
   output logic [16:0]              humidity,
   output logic [SideW-1:0]         out_side
);

   logic               vld_ff [0:6];
   logic [SideW-1:0]   side_ff [0:6];

   logic signed [31:0] hv_w;
   logic signed [43:0] xm_w;
   logic signed [39:0] y1m_w;
   logic signed [40:0] y2m_w;
   logic [31:0]        xa_in, xa_ff, xm_ff, y1m_ff, y2m_ff;
   logic signed [31:0] x_w, y1_w, y2_w, x2_ff, x3_ff;
   logic signed [63:0] ym_w;
   logic [31:0]        ym_ff;
   logic signed [31:0] y_w;
   logic signed [47:0] yh_w;
   logic [31:0]        yh_ff;
   logic signed [31:0] yy_w;
   logic signed [63:0] hv_full;
   logic [31:0]        hv_ff, hv5_ff, hv6_ff;
   logic signed [31:0] s_w;
   logic signed [63:0] ss_w;
   logic [31:0]        sqm_ff;
   logic signed [31:0] sq_w;
   logic signed [40:0] sh_w;
   logic [31:0]        sh_ff;
   logic signed [31:0] shs_w;
   logic [31:0]        r_w, rc_w;
   logic [16:0]        hum_ff;

   always_comb begin
      hv_w    = fine_temp - esc_pkg::TempHumOffset;
      xm_w    = hv_w * $signed(cal.h5);
      y1m_w   = hv_w * $signed(cal.h6);
      y2m_w   = hv_w * $signed({1'b0, cal.h3});
      xa_in   = {2'b00, raw_humidity, 14'd0} - {cal.h4, 20'd0};
      x_w     = $signed(xa_ff - xm_ff + esc_pkg::HumRoundX) >>> 15;
      y1_w    = $signed(y1m_ff) >>> 10;
      y2_w    = ($signed(y2m_ff) >>> 11) + esc_pkg::HumOffsetY2;
      ym_w    = y1_w * y2_w;
      y_w     = ($signed(ym_ff) >>> 10) + esc_pkg::HumOffsetY;
      yh_w    = y_w * $signed(cal.h2);
      yy_w    = $signed(yh_ff + esc_pkg::HumRoundY) >>> 14;
      hv_full = x3_ff * yy_w;
      s_w     = $signed(hv_ff) >>> 15;
      ss_w    = s_w * s_w;
      sq_w    = $signed(sqm_ff) >>> 7;
      sh_w    = sq_w * $signed({1'b0, cal.h1});
      shs_w   = $signed(sh_ff) >>> 4;
      r_w     = hv6_ff - shs_w;
      // clamp: negative to zero, above full scale to full scale
      if (r_w[31]) begin
         rc_w = 32'd0;
      end else if (r_w > esc_pkg::HumLimit) begin
         rc_w = esc_pkg::HumLimit;
      end else begin
         rc_w = r_w;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 7; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i < 7; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         for (int i = 1; i < 7; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         xa_ff  <= xa_in;
         xm_ff  <= xm_w[31:0];
         y1m_ff <= y1m_w[31:0];
         y2m_ff <= y2m_w[31:0];
         x2_ff  <= x_w;
         ym_ff  <= ym_w[31:0];
         x3_ff  <= x2_ff;
         yh_ff  <= yh_w[31:0];
         hv_ff  <= hv_full[31:0];
         sqm_ff <= ss_w[31:0];
         hv5_ff <= hv_ff;
         sh_ff  <= sh_w[31:0];
         hv6_ff <= hv5_ff;
         hum_ff <= rc_w[28:12];
      end
   end

   assign out_valid = vld_ff[6];
   assign humidity  = hum_ff;
   assign out_side  = side_ff[6];

endmodule

`default_nettype wire

// ----- hdl/esc_pres_pre.sv -----
// -----------------------------------------------------------------------------
// esc_pres_pre: pressure numerator and divisor
// Five stages of 64-bit wrapping arithmetic; wide products are cut into
// 32-bit partial products and summed in the following stage.
// -----------------------------------------------------------------------------
`default_nettype none

module esc_pres_pre #(
   parameter int SideW = 81
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_valid,
   input  wire logic signed [31:0]  fine_temp,
   input  wire logic [19:0]         raw_pressure,
   input  wire esc_pkg::cal_type    cal,
   input  wire logic [SideW-1:0]    in_side,
   output logic                     out_valid,
   output logic [63:0]              numer,
   output logic [63:0]              denom,
   output logic [SideW-1:0]         out_side
);

   logic               vld_ff [0:4];
   logic [SideW-1:0]   side_ff [0:4];

   logic signed [33:0] v_w;
   logic signed [67:0] sq_w;
   logic signed [49:0] pv5_w, pv2_w, pv5_ff, pv2_ff, pv5b_ff, pv2b_ff;
   logic [63:0]        sq_ff;
   logic [20:0]        pd_ff, pd2_ff, pd3_ff;
   logic signed [48:0] lo6_w, lo3_w, lo6_ff, lo3_ff;
   logic signed [47:0] hi6_w, hi3_w;
   logic [31:0]        hi6_ff, hi3_ff;
   logic [63:0]        v2a_w, v3a_w, v2_in, v2_ff;
   logic signed [63:0] v3s_w, v1a_in, v1a_ff;
   logic [63:0]        w_w, nd_w;
   logic [47:0]        wl_w, wh_w;
   logic [43:0]        nl_w, nh_w;
   logic [47:0]        wl_ff;
   logic [31:0]        wh_ff, nh_ff;
   logic [43:0]        nl_ff;
   logic [63:0]        wp_w;
   logic [63:0]        num_ff, den_ff;

   always_comb begin
      // stage 1: offset fine temperature and its first products
      v_w   = $signed({{2{fine_temp[31]}}, fine_temp}) - esc_pkg::TempPresOffset;
      sq_w  = v_w * v_w;
      pv5_w = v_w * $signed(cal.p5);
      pv2_w = v_w * $signed(cal.p2);
      // stage 2: square times P6 and P3 in 32-bit halves
      lo6_w = $signed({1'b0, sq_ff[31:0]}) * $signed(cal.p6);
      hi6_w = $signed(sq_ff[63:32]) * $signed(cal.p6);
      lo3_w = $signed({1'b0, sq_ff[31:0]}) * $signed(cal.p3);
      hi3_w = $signed(sq_ff[63:32]) * $signed(cal.p3);
      // stage 3: sum the halves, add the shifted terms
      v2a_w  = {{15{lo6_ff[48]}}, lo6_ff} + {hi6_ff, 32'd0};
      v2_in  = v2a_w + {pv5b_ff[46:0], 17'd0} + {{13{cal.p4[15]}}, cal.p4, 35'd0};
      v3a_w  = {{15{lo3_ff[48]}}, lo3_ff} + {hi3_ff, 32'd0};
      v3s_w  = $signed(v3a_w) >>> 8;
      v1a_in = v3s_w + $signed({{2{pv2b_ff[49]}}, pv2b_ff, 12'd0});
      // stage 4: divisor and numerator products in halves
      w_w  = esc_pkg::PresBias47 + v1a_ff;
      wl_w = w_w[31:0] * cal.p1;
      wh_w = w_w[63:32] * cal.p1;
      nd_w = {12'd0, pd3_ff, 31'd0} - v2_ff;
      nl_w = nd_w[31:0] * esc_pkg::PresScale;
      nh_w = nd_w[63:32] * esc_pkg::PresScale;
      // stage 5: finish the divisor
      wp_w = {16'd0, wl_ff} + {wh_ff, 32'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 5; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i < 5; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         for (int i = 1; i < 5; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         sq_ff   <= sq_w[63:0];
         pv5_ff  <= pv5_w;
         pv2_ff  <= pv2_w;
         pd_ff   <= esc_pkg::PresFull - {1'b0, raw_pressure};
         lo6_ff  <= lo6_w;
         hi6_ff  <= hi6_w[31:0];
         lo3_ff  <= lo3_w;
         hi3_ff  <= hi3_w[31:0];
         pv5b_ff <= pv5_ff;
         pv2b_ff <= pv2_ff;
         pd2_ff  <= pd_ff;
         v2_ff   <= v2_in;
         v1a_ff  <= v1a_in;
         pd3_ff  <= pd2_ff;
         wl_ff   <= wl_w;
         wh_ff   <= wh_w[31:0];
         nl_ff   <= nl_w;
         nh_ff   <= nh_w[31:0];
         den_ff  <= 64'($signed(wp_w) >>> 33);
         num_ff  <= {20'd0, nl_ff} + {nh_ff, 32'd0};
      end
   end

   assign out_valid = vld_ff[4];
   assign numer     = num_ff;
   assign denom     = den_ff;
   assign out_side  = side_ff[4];

endmodule

`default_nettype wire

// ----- hdl/esc_div.sv -----
// -----------------------------------------------------------------------------
// esc_div: pipelined signed 64-bit divider
// Magnitude setup, one restoring step per stage, then sign fix-up. A zero
// divisor is flagged; its quotient is left to the caller to discard.
// -----------------------------------------------------------------------------
`default_nettype none

module esc_div #(
   parameter int SideW = 81
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_valid,
   input  wire logic [63:0]         numer,
   input  wire logic [63:0]         denom,
   input  wire logic [SideW-1:0]    in_side,
   output logic                     out_valid,
   output logic [63:0]              quotient,
   output logic                     div_zero,
   output logic [SideW-1:0]         out_side
);

   localparam int Steps = esc_pkg::DivSteps;

   logic               vld_ff [0:Steps];
   logic [SideW-1:0]   side_ff [0:Steps];
   logic [63:0]        rem_ff [0:Steps];
   logic [63:0]        nq_ff [0:Steps];
   logic [63:0]        dvs_ff [0:Steps];
   logic               neg_ff [0:Steps];
   logic               zero_ff [0:Steps];

   logic               vout_ff;
   logic [63:0]        q_ff;
   logic               zout_ff;
   logic [SideW-1:0]   sout_ff;

   // setup: magnitudes and result sign
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= 64'd0;
         nq_ff[0]   <= numer[63] ? 64'd0 - numer : numer;
         dvs_ff[0]  <= denom[63] ? 64'd0 - denom : denom;
         neg_ff[0]  <= numer[63] ^ denom[63];
         zero_ff[0] <= (denom == 64'd0);
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 0; k < Steps; k++) begin : g_step
      logic [64:0] trial_w;
      logic        ge_w;
      logic [64:0] diff_w;

      always_comb begin
         trial_w = {rem_ff[k], nq_ff[k][63]};
         diff_w  = trial_w - {1'b0, dvs_ff[k]};
         ge_w    = !diff_w[64];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= ge_w ? diff_w[63:0] : trial_w[63:0];
            nq_ff[k+1]   <= {nq_ff[k][62:0], ge_w};
            dvs_ff[k+1]  <= dvs_ff[k];
            neg_ff[k+1]  <= neg_ff[k];
            zero_ff[k+1] <= zero_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   // sign fix-up
   always_ff @(posedge clock) begin
      if (reset) begin
         vout_ff <= 1'b0;
      end else if (en) begin
         vout_ff <= vld_ff[Steps];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff    <= neg_ff[Steps] ? 64'd0 - nq_ff[Steps] : nq_ff[Steps];
         zout_ff <= zero_ff[Steps];
         sout_ff <= side_ff[Steps];
      end
   end

   assign out_valid = vout_ff;
   assign quotient  = q_ff;
   assign div_zero  = zout_ff;
   assign out_side  = sout_ff;

endmodule

`default_nettype wire

// ----- hdl/esc_pres_post.sv -----
// -----------------------------------------------------------------------------
// esc_pres_post: pressure correction after the division
// Five stages: the P9 quadratic and P8 linear corrections in 32-bit
// partial products, then the Q24.8 sum with the P7 offset.
// -----------------------------------------------------------------------------
`default_nettype none

module esc_pres_post #(
   parameter int SideW = 81
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_valid,
   input  wire logic [63:0]         quotient,
   input  wire logic                div_zero,
   input  wire esc_pkg::cal_type    cal,
   input  wire logic [SideW-1:0]    in_side,
   output logic                     out_valid,
   output logic [31:0]              pressure,
   output logic                     pres_invalid,
   output logic [SideW-1:0]         out_side
);

   logic               vld_ff [0:4];
   logic [SideW-1:0]   side_ff [0:4];
   logic               zero_ff [0:4];
   logic [63:0]        q_ff [0:3];

   logic [63:0]        r_w;
   logic signed [48:0] al_w, bl_w;
   logic signed [47:0] ah_w, bh_w;
   logic [63:0]        r_ff, r2_ff;
   logic signed [48:0] al_ff, bl_ff;
   logic [31:0]        ah_ff, bh_ff;
   logic [63:0]        m_w, b_w;
   logic [63:0]        m_ff, v2_ff, v2b_ff, v2c_ff;
   logic [63:0]        c0_w, c1_w, c2_w;
   logic [63:0]        c0_ff;
   logic [31:0]        c1_ff, c2_ff;
   logic [63:0]        mr_w, v1_ff, sum_w, pres_w;
   logic [31:0]        pres_ff;

   always_comb begin
      // stage 1: P9 times the shifted quotient, P8 times the quotient
      r_w  = 64'($signed(quotient) >>> 13);
      al_w = $signed({1'b0, r_w[31:0]}) * $signed(cal.p9);
      ah_w = $signed(r_w[63:32]) * $signed(cal.p9);
      bl_w = $signed({1'b0, quotient[31:0]}) * $signed(cal.p8);
      bh_w = $signed(quotient[63:32]) * $signed(cal.p8);
      // stage 2: assemble the products
      m_w  = {{15{al_ff[48]}}, al_ff} + {ah_ff, 32'd0};
      b_w  = {{15{bl_ff[48]}}, bl_ff} + {bh_ff, 32'd0};
      // stage 3: second factor of the quadratic term
      c0_w = m_ff[31:0] * r2_ff[31:0];
      c1_w = m_ff[31:0] * r2_ff[63:32];
      c2_w = m_ff[63:32] * r2_ff[31:0];
      // stage 4
      mr_w = c0_ff + {c1_ff + c2_ff, 32'd0};
      // stage 5: sum, scale and offset
      sum_w  = q_ff[3] + v1_ff + v2c_ff;
      pres_w = 64'($signed(sum_w) >>> 8) + {{44{cal.p7[15]}}, cal.p7, 4'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 5; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i < 5; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         zero_ff[0] <= div_zero;
         q_ff[0]    <= quotient;
         for (int i = 1; i < 5; i++) begin
            side_ff[i] <= side_ff[i-1];
            zero_ff[i] <= zero_ff[i-1];
         end
         for (int i = 1; i < 4; i++) begin
            q_ff[i] <= q_ff[i-1];
         end
         r_ff    <= r_w;
         al_ff   <= al_w;
         ah_ff   <= ah_w[31:0];
         bl_ff   <= bl_w;
         bh_ff   <= bh_w[31:0];
         m_ff    <= m_w;
         v2_ff   <= 64'($signed(b_w) >>> 19);
         r2_ff   <= r_ff;
         c0_ff   <= c0_w;
         c1_ff   <= c1_w[31:0];
         c2_ff   <= c2_w[31:0];
         v2b_ff  <= v2_ff;
         v1_ff   <= 64'($signed(mr_w) >>> 25);
         v2c_ff  <= v2b_ff;
         // drop the result of a zero divisor
         pres_ff <= zero_ff[3] ? 32'd0 : pres_w[31:0];
      end
   end

   assign out_valid    = vld_ff[4];
   assign pressure     = pres_ff;
   assign pres_invalid = zero_ff[4];
   assign out_side     = side_ff[4];

endmodule

`default_nettype wire

// ----- hdl/environmental_sensor_compensation.sv -----
// -----------------------------------------------------------------------------
// environmental_sensor_compensation: integer compensation of raw readings
// Depth: 88 register stages from an accepted req transfer to rsp_valid.
// Throughput: one transfer per cycle unless rsp_stall holds the output; every
//   stage is a register stage and the 64-step pressure divider is fully
//   pipelined, one quotient bit per stage.
// Reset: synchronous, active high; clears all valid bits and the calibration
//   registers to zero. No clearing pass; the block takes items right away.
// -----------------------------------------------------------------------------
`default_nettype none

module environmental_sensor_compensation (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // input channel
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire esc_pkg::req_type               req_data,
   // result channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output esc_pkg::rsp_type                    rsp_data,
   // calibration register writes
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [esc_pkg::CsrIdxW-1:0]    csr_index,
   input  wire logic [63:0]                    csr_data
);

   // Side-data widths along the chain of pipelines
   localparam int TempSideW = 36;   // raw humidity, raw pressure
   localparam int HumSideW  = 84;   // temperature, fine temperature, raw pressure
   localparam int PresSideW = 81;   // temperature, fine temperature, humidity

   // Calibration registers, packed as written
   logic [47:0] temp_cal_ff;
   logic [47:0] pres_a_ff;
   logic [63:0] pres_b_ff;
   logic [31:0] pres_c_ff;
   logic [39:0] hum_a_ff;
   logic [23:0] hum_b_ff;

   esc_pkg::cal_type cal;

   // Global advance: the whole pipeline moves when the output register
   // is empty or its transfer completes in this cycle.
   logic en;

   logic                    t_valid;
   logic signed [31:0]      t_fine, t_centi;
   logic [TempSideW-1:0]    t_side;

   logic                    h_valid;
   logic [16:0]             h_hum;
   logic [HumSideW-1:0]     h_side;

   logic                    p_valid;
   logic [63:0]             p_num, p_den;
   logic [PresSideW-1:0]    p_side;

   logic                    d_valid;
   logic [63:0]             d_quo;
   logic                    d_zero;
   logic [PresSideW-1:0]    d_side;

   logic                    o_valid;
   logic [31:0]             o_pres;
   logic                    o_invalid;
   logic [PresSideW-1:0]    o_side;

   logic                    rsp_valid_ff;
   esc_pkg::rsp_type        rsp_ff;

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;
   assign csr_ready = 1'b1;

   // ---------------------------------------------------------------------------
   // Calibration registers. Writes to indexes beyond the list are dropped.
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_cal_ff <= '0;
         pres_a_ff   <= '0;
         pres_b_ff   <= '0;
         pres_c_ff   <= '0;
         hum_a_ff    <= '0;
         hum_b_ff    <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            esc_pkg::CSR_TEMP_CAL: temp_cal_ff <= csr_data[47:0];
            esc_pkg::CSR_PRES_A:   pres_a_ff   <= csr_data[47:0];
            esc_pkg::CSR_PRES_B:   pres_b_ff   <= csr_data;
            esc_pkg::CSR_PRES_C:   pres_c_ff   <= csr_data[31:0];
            esc_pkg::CSR_HUM_A:    hum_a_ff    <= csr_data[39:0];
            esc_pkg::CSR_HUM_B:    hum_b_ff    <= csr_data[23:0];
            default: begin
            end
         endcase
      end
   end

   // Split the packed registers into the individual calibration words
   always_comb begin
      cal.t1 = temp_cal_ff[15:0];
      cal.t2 = temp_cal_ff[31:16];
      cal.t3 = temp_cal_ff[47:32];
      cal.p1 = pres_a_ff[15:0];
      cal.p2 = pres_a_ff[31:16];
      cal.p3 = pres_a_ff[47:32];
      cal.p4 = pres_b_ff[15:0];
      cal.p5 = pres_b_ff[31:16];
      cal.p6 = pres_b_ff[47:32];
      cal.p7 = pres_b_ff[63:48];
      cal.p8 = pres_c_ff[15:0];
      cal.p9 = pres_c_ff[31:16];
      cal.h1 = hum_a_ff[7:0];
      cal.h2 = hum_a_ff[23:8];
      cal.h3 = hum_a_ff[31:24];
      cal.h6 = hum_a_ff[39:32];
      cal.h4 = hum_b_ff[11:0];
      cal.h5 = hum_b_ff[23:12];
   end

   // ---------------------------------------------------------------------------
   // Temperature: fine temperature and centi-degrees (4 stages)
   // ---------------------------------------------------------------------------
   esc_temp #(
      .SideW (TempSideW)
   ) u_temp (
      .clock           (clock),
      .reset           (reset),
      .en              (en),
      .in_valid        (req_valid),
      .raw_temperature (req_data.raw_temperature),
      .cal             (cal),
      .in_side         ({req_data.raw_humidity, req_data.raw_pressure}),
      .out_valid       (t_valid),
      .fine_temp       (t_fine),
      .temp_centi      (t_centi),
      .out_side        (t_side)
   );

   // ---------------------------------------------------------------------------
   // Humidity (7 stages); carry temperature and raw pressure alongside
   // ---------------------------------------------------------------------------
   esc_hum #(
      .SideW (HumSideW)
   ) u_hum (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (t_valid),
      .fine_temp    (t_fine),
      .raw_humidity (t_side[35:20]),
      .cal          (cal),
      .in_side      ({t_centi, t_fine, t_side[19:0]}),
      .out_valid    (h_valid),
      .humidity     (h_hum),
      .out_side     (h_side)
   );

   // ---------------------------------------------------------------------------
   // Pressure numerator and divisor (5 stages)
   // ---------------------------------------------------------------------------
   esc_pres_pre #(
      .SideW (PresSideW)
   ) u_pres_pre (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (h_valid),
      .fine_temp    (h_side[51:20]),
      .raw_pressure (h_side[19:0]),
      .cal          (cal),
      .in_side      ({h_side[83:52], h_side[51:20], h_hum}),
      .out_valid    (p_valid),
      .numer        (p_num),
      .denom        (p_den),
      .out_side     (p_side)
   );

   // ---------------------------------------------------------------------------
   // Signed division (66 stages)
   // ---------------------------------------------------------------------------
   esc_div #(
      .SideW (PresSideW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p_valid),
      .numer     (p_num),
      .denom     (p_den),
      .in_side   (p_side),
      .out_valid (d_valid),
      .quotient  (d_quo),
      .div_zero  (d_zero),
      .out_side  (d_side)
   );

   // ---------------------------------------------------------------------------
   // Pressure correction terms and Q24.8 result (5 stages)
   // ---------------------------------------------------------------------------
   esc_pres_post #(
      .SideW (PresSideW)
   ) u_pres_post (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (d_valid),
      .quotient     (d_quo),
      .div_zero     (d_zero),
      .cal          (cal),
      .in_side      (d_side),
      .out_valid    (o_valid),
      .pressure     (o_pres),
      .pres_invalid (o_invalid),
      .out_side     (o_side)
   );

   // ---------------------------------------------------------------------------
   // Output register: hold the result while the consumer stalls
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= o_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff.temperature_centi <= o_side[80:49];
         rsp_ff.fine_temperature  <= o_side[48:17];
         rsp_ff.pressure_q24_8    <= o_pres;
         rsp_ff.pressure_invalid  <= o_invalid;
         rsp_ff.humidity_q22_10   <= o_side[16:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------

   // A flagged zero divisor always comes with a zero pressure
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.pressure_invalid |-> rsp_data.pressure_q24_8 == 32'd0)
      else $error("pressure flagged invalid but not zero");

   // Humidity stays within the clamp range
   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.humidity_q22_10 <= esc_pkg::HumMax)
      else $error("humidity above full scale");

   // A completed transfer with nothing behind it leaves the output empty
   a_no_repeat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !o_valid |=> !rsp_valid)
      else $error("result repeated after transfer");

endmodule

`default_nettype wire

// ----- verif/environmental_sensor_compensation_test.sv -----
// -----------------------------------------------------------------------------
// environmental_sensor_compensation_test: self-checking bench for compensation
// Drives raw measurement triples through the block under several calibration
// sets. A scoreboard predicts each compensated result and checks it, field by
// field, against the result transfers in order.
// -----------------------------------------------------------------------------
`default_nettype none

module environmental_sensor_compensation_test;

   localparam int                 HalfPeriod   = 2;
   localparam int                 StallLimit   = 5000;  // cycles with no transfer
   localparam int                 SettleCycles = 120;   // above the pipeline depth
   localparam int                 LongHold     = 400;   // well beyond pipeline depth
   localparam logic [esc_pkg::CsrIdxW-1:0] CsrIdxUnused = 3'd7;  // no register here

   // ---------------------------------------------------------------------------
   // Scoreboard: calibration copy, compensation predictor, queue of results due
   // ---------------------------------------------------------------------------
   class compensation_scoreboard;
      bit [63:0]        cal[6];
      esc_pkg::rsp_type results_due[$];
      int               errors;
      int               checked;
      int               invalid_seen;
      int               clamp_seen;

      function new();
         foreach (cal[i]) cal[i] = '0;
         errors = 0;
         checked = 0;
         invalid_seen = 0;
         clamp_seen = 0;
      endfunction

      // Mask the value to the register width; drop writes to unused indexes.
      function void write_cal(logic [esc_pkg::CsrIdxW-1:0] idx, bit [63:0] value);
         case (idx)
            esc_pkg::CSR_TEMP_CAL: cal[idx] = value & 64'hFFFF_FFFF_FFFF;
            esc_pkg::CSR_PRES_A:   cal[idx] = value & 64'hFFFF_FFFF_FFFF;
            esc_pkg::CSR_PRES_B:   cal[idx] = value;
            esc_pkg::CSR_PRES_C:   cal[idx] = value & 64'hFFFF_FFFF;
            esc_pkg::CSR_HUM_A:    cal[idx] = value & 64'hFF_FFFF_FFFF;
            esc_pkg::CSR_HUM_B:    cal[idx] = value & 64'hFF_FFFF;
            default: ;
         endcase
      endfunction

      function bit [31:0] sra32(bit [31:0] x, int s);
         return $signed(x) >>> s;
      endfunction

      function bit [63:0] sra64(bit [63:0] x, int s);
         return $signed(x) >>> s;
      endfunction

      // Signed 64-bit division, truncating toward zero, wrapping on overflow.
      function bit [63:0] sdiv64(bit [63:0] n, bit [63:0] d);
         bit [63:0] un, ud, q;
         un = n[63] ? -n : n;
         ud = d[63] ? -d : d;
         q = un / ud;
         return (n[63] != d[63]) ? -q : q;
      endfunction

      function esc_pkg::rsp_type compensate(esc_pkg::req_type r);
         bit [31:0] at, ah, t1, t2, t3, h1, h2, h3, h4, h5, h6;
         bit [63:0] ap, p1, p2, p3, p4, p5, p6, p7, p8, p9;
         bit [31:0] a, d, tv1, tv2, tf, tc, hv, x, y1, y2, y, sq;
         bit [63:0] v1, v2, p, pres;
         esc_pkg::rsp_type o;
         at = 32'(r.raw_temperature);
         ap = 64'(r.raw_pressure);
         ah = 32'(r.raw_humidity);
         t1 = 32'(cal[esc_pkg::CSR_TEMP_CAL][15:0]);
         t2 = 32'($signed(cal[esc_pkg::CSR_TEMP_CAL][31:16]));
         t3 = 32'($signed(cal[esc_pkg::CSR_TEMP_CAL][47:32]));
         p1 = 64'(cal[esc_pkg::CSR_PRES_A][15:0]);
         p2 = 64'($signed(cal[esc_pkg::CSR_PRES_A][31:16]));
         p3 = 64'($signed(cal[esc_pkg::CSR_PRES_A][47:32]));
         p4 = 64'($signed(cal[esc_pkg::CSR_PRES_B][15:0]));
         p5 = 64'($signed(cal[esc_pkg::CSR_PRES_B][31:16]));
         p6 = 64'($signed(cal[esc_pkg::CSR_PRES_B][47:32]));
         p7 = 64'($signed(cal[esc_pkg::CSR_PRES_B][63:48]));
         p8 = 64'($signed(cal[esc_pkg::CSR_PRES_C][15:0]));
         p9 = 64'($signed(cal[esc_pkg::CSR_PRES_C][31:16]));
         h1 = 32'(cal[esc_pkg::CSR_HUM_A][7:0]);
         h2 = 32'($signed(cal[esc_pkg::CSR_HUM_A][23:8]));
         h3 = 32'(cal[esc_pkg::CSR_HUM_A][31:24]);
         h6 = 32'($signed(cal[esc_pkg::CSR_HUM_A][39:32]));
         h4 = 32'($signed(cal[esc_pkg::CSR_HUM_B][11:0]));
         h5 = 32'($signed(cal[esc_pkg::CSR_HUM_B][23:12]));

         // temperature, 32-bit wrapping
         a   = (at >> 3) - (t1 << 1);
         tv1 = sra32(a * t2, 11);
         d   = (at >> 4) - t1;
         tv2 = sra32(sra32(d * d, 12) * t3, 14);
         tf  = tv1 + tv2;
         tc  = sra32(tf * 5 + 128, 8);

         // pressure, 64-bit wrapping
         v1 = 64'($signed(tf)) - 64'd128000;
         v2 = v1 * v1 * p6;
         v2 = v2 + ((v1 * p5) << 17);
         v2 = v2 + (p4 << 35);
         v1 = sra64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
         v1 = sra64(((64'd1 << 47) + v1) * p1, 33);
         if (v1 == 0) begin
            pres = 0;
            o.pressure_invalid = 1'b1;
         end else begin
            p    = 64'd1048576 - ap;
            p    = sdiv64(((p << 31) - v2) * 64'd3125, v1);
            v1   = sra64(p9 * sra64(p, 13) * sra64(p, 13), 25);
            v2   = sra64(p8 * p, 19);
            pres = sra64(p + v1 + v2, 8) + (p7 << 4);
            o.pressure_invalid = 1'b0;
         end

         // humidity, 32-bit wrapping, then clamp
         hv = tf - 32'd76800;
         x  = (ah << 14) - (h4 << 20) - h5 * hv;
         x  = sra32(x + 32'd16384, 15);
         y1 = sra32(hv * h6, 10);
         y2 = sra32(hv * h3, 11) + 32'd32768;
         y  = sra32(y1 * y2, 10) + 32'd2097152;
         y  = sra32(y * h2 + 32'd8192, 14);
         hv = x * y;
         sq = sra32(sra32(hv, 15) * sra32(hv, 15), 7);
         hv = hv - sra32(sq * h1, 4);
         if (hv[31]) hv = 0;
         else if (hv > 32'd419430400) hv = 32'd419430400;

         o.temperature_centi = tc;
         o.fine_temperature  = tf;
         o.pressure_q24_8    = pres[31:0];
         o.humidity_q22_10   = 17'(hv >> 12);
         return o;
      endfunction

      function void note_input(esc_pkg::req_type r);
         esc_pkg::rsp_type e;
         e = compensate(r);
         if (e.pressure_invalid) invalid_seen++;
         if (e.humidity_q22_10 == 0 || e.humidity_q22_10 == 17'd102400) clamp_seen++;
         results_due.push_back(e);
      endfunction

      function void check_result(esc_pkg::rsp_type got);
         esc_pkg::rsp_type e;
         if (results_due.size() == 0) begin
            $display("%0t: unexpected result transfer %h", $time, got);
            errors++;
            return;
         end
         e = results_due.pop_front();
         checked++;
         if (got.temperature_centi !== e.temperature_centi) begin
            $display("%0t: temperature_centi expected %0d got %0d", $time,
                     e.temperature_centi, got.temperature_centi);
            errors++;
         end
         if (got.fine_temperature !== e.fine_temperature) begin
            $display("%0t: fine_temperature expected %0d got %0d", $time,
                     e.fine_temperature, got.fine_temperature);
            errors++;
         end
         if (got.pressure_q24_8 !== e.pressure_q24_8) begin
            $display("%0t: pressure_q24_8 expected %h got %h", $time,
                     e.pressure_q24_8, got.pressure_q24_8);
            errors++;
         end
         if (got.pressure_invalid !== e.pressure_invalid) begin
            $display("%0t: pressure_invalid expected %b got %b", $time,
                     e.pressure_invalid, got.pressure_invalid);
            errors++;
         end
         if (got.humidity_q22_10 !== e.humidity_q22_10) begin
            $display("%0t: humidity_q22_10 expected %0d got %0d", $time,
                     e.humidity_q22_10, got.humidity_q22_10);
            errors++;
         end
      endfunction
   endclass

   // ---------------------------------------------------------------------------
   // Block under test
   // ---------------------------------------------------------------------------
   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   esc_pkg::req_type            req_data = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   esc_pkg::rsp_type            rsp_data;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [esc_pkg::CsrIdxW-1:0] csr_index = '0;
   logic [63:0]                 csr_data = '0;

   environmental_sensor_compensation dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   always #HalfPeriod clock = ~clock;

   compensation_scoreboard sb = new();

   int sender_idle_pct   = 0;   // chance of a gap before each offered item
   int receiver_idle_pct = 0;   // chance of stall per cycle
   int hold_left         = 0;   // remaining cycles of a forced long stall
   int idle_cycles       = 0;
   int sent              = 0;

   // Receiver: random stall, or a long hold-off counted here.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   // Check every result transfer as it happens.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   // Watchdog: give up when nothing moves for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
         $display("%0t: no transfer for %0d cycles", $time, StallLimit);
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------------
   // Offer one register write and hold it until taken.
   task automatic write_csr(logic [esc_pkg::CsrIdxW-1:0] idx, bit [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.write_cal(idx, value);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic program_cal(bit [63:0] tcal, bit [63:0] pa, bit [63:0] pb,
                              bit [63:0] pc, bit [63:0] ha, bit [63:0] hb);
      write_csr(esc_pkg::CSR_TEMP_CAL, tcal);
      write_csr(esc_pkg::CSR_PRES_A, pa);
      write_csr(esc_pkg::CSR_PRES_B, pb);
      write_csr(esc_pkg::CSR_PRES_C, pc);
      write_csr(esc_pkg::CSR_HUM_A, ha);
      write_csr(esc_pkg::CSR_HUM_B, hb);
   endtask

   // Offer one reading; leave valid high so back-to-back items need no gap.
   task automatic send_reading(bit [19:0] rt, bit [19:0] rp, bit [15:0] rh);
      esc_pkg::req_type r;
      r.raw_temperature = rt;
      r.raw_pressure    = rp;
      r.raw_humidity    = rh;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      sb.note_input(r);
      sent++;
      @(negedge clock);
   endtask

   // Drop valid, wait for every result due, then let the pipeline settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.results_due.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      @(negedge clock);
   endtask

   // Typical factory calibration for each register index.
   function automatic bit [63:0] typical_cal(int idx);
      case (idx)
         esc_pkg::CSR_TEMP_CAL: return {16'hFC18, 16'd26435, 16'd27504};
         esc_pkg::CSR_PRES_A:   return {16'd3024, 16'hD643, 16'd36477};
         esc_pkg::CSR_PRES_B:   return {16'd15500, 16'hFFF9, 16'd140, 16'd2855};
         esc_pkg::CSR_PRES_C:   return {16'd6000, 16'hC6F8};
         esc_pkg::CSR_HUM_A:    return {8'd30, 8'd0, 16'd362, 8'd75};
         default:               return {12'd50, 12'd313};
      endcase
   endfunction

   function automatic bit [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Mostly small perturbations of a real part, sometimes anything at all.
   function automatic bit [63:0] random_cal(int idx);
      if ($urandom_range(3) == 0) return rand64();
      return typical_cal(idx) ^ (rand64() & {4{16'h00FF}});
   endfunction

   task automatic random_readings(int count);
      bit [19:0] rt, rp;
      bit [15:0] rh;
      repeat (count) begin
         case ($urandom_range(9))
            0: begin
               rt = $urandom_range(1) ? 20'hFFFFF : 20'h0;
               rp = $urandom_range(1) ? 20'hFFFFF : 20'h0;
               rh = $urandom_range(1) ? 16'hFFFF : 16'h0;
            end
            1, 2, 3: begin
               rt = 20'($urandom);
               rp = 20'($urandom);
               rh = 16'($urandom);
            end
            default: begin
               // Plausible indoor readings
               rt = 20'($urandom_range(560000, 460000));
               rp = 20'($urandom_range(480000, 330000));
               rh = 16'($urandom_range(40000, 20000));
            end
         endcase
         send_reading(rt, rp, rh);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------
   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset calibration: P1 is zero, so the pressure divisor is zero.
      send_reading(20'h0, 20'h0, 16'h0);
      send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
      send_reading(20'h7EEE0, 20'h65A2C, 16'h6E8C);
      drain();

      // Typical calibration; extremes and alternating patterns of every field.
      program_cal(typical_cal(esc_pkg::CSR_TEMP_CAL), typical_cal(esc_pkg::CSR_PRES_A),
                  typical_cal(esc_pkg::CSR_PRES_B), typical_cal(esc_pkg::CSR_PRES_C),
                  typical_cal(esc_pkg::CSR_HUM_A), typical_cal(esc_pkg::CSR_HUM_B));
      write_csr(CsrIdxUnused, rand64());  // must leave every register alone
      send_reading(20'd519888, 20'd415148, 16'd30000);
      send_reading(20'h0, 20'h0, 16'h0);
      send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
      send_reading(20'hAAAAA, 20'h55555, 16'hAAAA);
      send_reading(20'h55555, 20'hAAAAA, 16'h5555);
      send_reading(20'd519888, 20'd415148, 16'hFFFF);  // humidity clamps high
      send_reading(20'd519888, 20'd415148, 16'h0);     // humidity clamps to zero
      send_reading(20'h0, 20'hFFFFF, 16'd30000);
      send_reading(20'hFFFFF, 20'h0, 16'd30000);
      drain();

      // Extreme calibration: every register all ones, then stray high bits.
      program_cal({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}},
                  {64{1'b1}});
      send_reading(20'h0, 20'h0, 16'h0);
      send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
      send_reading(20'd519888, 20'd415148, 16'd30000);
      drain();
      program_cal(64'h8000_8000_7FFF_8000, 64'h8000_7FFF_8000_FFFF,
                  64'h7FFF_8000_7FFF_8000, 64'hFFFF_FFFF_8000_7FFF,
                  64'hFFFF_FF80_FF80_00FF, 64'hFFFF_FFFF_FF80_0800);
      send_reading(20'h0, 20'hFFFFF, 16'hFFFF);
      send_reading(20'hFFFFF, 20'h0, 16'h0);
      send_reading(20'd519888, 20'd415148, 16'd30000);
      drain();

      // Random part: seven calibration sets of a hundred readings each.
      for (int phase = 0; phase < 7; phase++) begin
         if (phase == 3) program_cal(64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0);
         else program_cal(random_cal(esc_pkg::CSR_TEMP_CAL),
                          random_cal(esc_pkg::CSR_PRES_A),
                          random_cal(esc_pkg::CSR_PRES_B),
                          random_cal(esc_pkg::CSR_PRES_C),
                          random_cal(esc_pkg::CSR_HUM_A),
                          random_cal(esc_pkg::CSR_HUM_B));
         if (phase < 3) begin
            sender_idle_pct   = 25;
            receiver_idle_pct = 76;
         end else if (phase < 5) begin
            sender_idle_pct   = 76;
            receiver_idle_pct = 25;
         end else begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         // Fill the pipeline against a long hold-off so the input stalls.
         if (phase == 5) hold_left = LongHold;
         random_readings(100);
         drain();
      end

      $display("Sent %0d readings, checked %0d results (%0d with zero divisor,",
               sent, sb.checked, sb.invalid_seen);
      $display("  %0d at a humidity limit) over eleven calibration sets.",
               sb.clamp_seen);
      if (sb.errors == 0 && sb.results_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
hdl/esc_pkg.sv
hdl/esc_temp.sv
hdl/esc_hum.sv
hdl/esc_pres_pre.sv
hdl/esc_div.sv
hdl/esc_pres_post.sv
hdl/environmental_sensor_compensation.sv
verif/environmental_sensor_compensation_test.sv
